/* design/hhmc_pkg.sv */
// Package for the Hodgkin-Huxley membrane current core.
// Field widths, fixed-point limits, pipeline control type and the rounded multiply.
// No dependencies.
`default_nettype none

package hhmc_pkg;

   // Field widths
   localparam int VOLT_W = 17;
   localparam int GATE_W = 17;
   localparam int COND_W = 25;
   localparam int ION_W  = 26;
   localparam int TOT_W  = 28;
   localparam int STOT_W = 26;

   // Stream word widths (fields packed from bit 0, padded to bytes)
   localparam int REQ_DATA_W = 200;
   localparam int RSP_DATA_W = 160;

   // Pipeline depth
   localparam int NUM_STAGES = 7;

   // Fixed-point limits
   localparam logic [GATE_W-1:0] GATE_ONE = 17'h10000;
   localparam logic [COND_W-1:0] COND_ONE = 25'h1000000;
   localparam logic signed [26:0] ION_CUR_MAX = 27'sd26214400;
   localparam logic signed [26:0] ION_CUR_MIN = -27'sd26214400;
   localparam logic signed [28:0] TOT_CUR_MAX = 29'sd78643200;
   localparam logic signed [28:0] TOT_CUR_MIN = -29'sd78643200;

   // Per-stage load enables and valid bits
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

   // (a*b + 0.5 lsb) >> 16, unsigned
   function automatic logic [26:0] mul_round(input logic [COND_W-1:0] a,
                                             input logic [GATE_W-1:0] b);
      logic [42:0] prod;
      prod = 43'(a) * 43'(b) + 43'h8000;
      return prod[42:16];
   endfunction

   // Q16 gate times Q16 gate, both at most one
   function automatic logic [GATE_W-1:0] gate_mul(input logic [GATE_W-1:0] a,
                                                  input logic [GATE_W-1:0] b);
      logic [26:0] r;
      r = mul_round(COND_W'(a), b);
      return r[GATE_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/hodgkin_huxley_membrane_current_core.sv */
// Hodgkin-Huxley ionic current core: conductances, currents and slopes per compartment.
// Throughput: one word per cycle while rsp_tready does not stall the pipeline.
// One multiplier per path per stage; the m^3*h and n^4 chains set the depth.
// Reset clears the pipeline valid bits only; payload registers are not reset.
// Uses hhmc_pkg and hhmc_pipe_ctrl.
`default_nettype none

module hodgkin_huxley_membrane_current_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // voltage[16:0], sodium_reversal[33:17], potassium_reversal[50:34],
   // leak_reversal[67:51], gate_m[84:68], gate_h[101:85], gate_n[118:102],
   // sodium_peak_conductance[143:119], potassium_peak_conductance[168:144],
   // leak_conductance[193:169], zero pad[199:194]
   input  wire logic [hhmc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // sodium_current[25:0], potassium_current[51:26], total_current[79:52],
   // sodium_slope[104:80], potassium_slope[129:105], total_slope[155:130],
   // zero pad[159:156]
   output logic [hhmc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready
);
   import hhmc_pkg::*;

   pipe_ctrl_type ctrl;

   hhmc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .ctrl      (ctrl)
   );

   // Input word unpack
   logic [VOLT_W-1:0] req_voltage, req_sodium_reversal, req_potassium_reversal;
   logic [VOLT_W-1:0] req_leak_reversal;
   logic [GATE_W-1:0] req_gate_m, req_gate_h, req_gate_n;
   logic [COND_W-1:0] req_sodium_peak_conductance, req_potassium_peak_conductance;
   logic [COND_W-1:0] req_leak_conductance;

   assign req_voltage                    = req_tdata[16:0];
   assign req_sodium_reversal            = req_tdata[33:17];
   assign req_potassium_reversal         = req_tdata[50:34];
   assign req_leak_reversal              = req_tdata[67:51];
   assign req_gate_m                     = req_tdata[84:68];
   assign req_gate_h                     = req_tdata[101:85];
   assign req_gate_n                     = req_tdata[118:102];
   assign req_sodium_peak_conductance    = req_tdata[143:119];
   assign req_potassium_peak_conductance = req_tdata[168:144];
   assign req_leak_conductance           = req_tdata[193:169];

   // ---------------- Stage 1: clamp, voltage differences ----------------
   logic [GATE_W-1:0] s1_m_ff, s1_h_ff, s1_n_ff, s1_m_in, s1_h_in, s1_n_in;
   logic [COND_W-1:0] s1_gna_bar_ff, s1_gk_bar_ff, s1_gl_ff;
   logic [COND_W-1:0] s1_gna_bar_in, s1_gk_bar_in, s1_gl_in;
   logic              s1_na_neg_ff, s1_k_neg_ff, s1_l_neg_ff;
   logic              s1_na_neg_in, s1_k_neg_in, s1_l_neg_in;
   logic [16:0]       s1_na_mag_ff, s1_k_mag_ff, s1_l_mag_ff;
   logic [16:0]       s1_na_mag_in, s1_k_mag_in, s1_l_mag_in;
   logic [17:0]       d_na, d_k, d_l, n_na, n_k, n_l;

   always_comb begin
      s1_m_in = (req_gate_m > GATE_ONE) ? GATE_ONE : req_gate_m;
      s1_h_in = (req_gate_h > GATE_ONE) ? GATE_ONE : req_gate_h;
      s1_n_in = (req_gate_n > GATE_ONE) ? GATE_ONE : req_gate_n;
      s1_gna_bar_in = (req_sodium_peak_conductance > COND_ONE) ?
                      COND_ONE : req_sodium_peak_conductance;
      s1_gk_bar_in  = (req_potassium_peak_conductance > COND_ONE) ?
                      COND_ONE : req_potassium_peak_conductance;
      s1_gl_in      = (req_leak_conductance > COND_ONE) ? COND_ONE : req_leak_conductance;
      // 18-bit signed differences, split into sign and magnitude
      d_na = {req_voltage[16], req_voltage} - {req_sodium_reversal[16], req_sodium_reversal};
      d_k  = {req_voltage[16], req_voltage}
             - {req_potassium_reversal[16], req_potassium_reversal};
      d_l  = {req_voltage[16], req_voltage} - {req_leak_reversal[16], req_leak_reversal};
      n_na = 18'd0 - d_na;
      n_k  = 18'd0 - d_k;
      n_l  = 18'd0 - d_l;
      s1_na_neg_in = d_na[17];
      s1_k_neg_in  = d_k[17];
      s1_l_neg_in  = d_l[17];
      s1_na_mag_in = d_na[17] ? n_na[16:0] : d_na[16:0];
      s1_k_mag_in  = d_k[17]  ? n_k[16:0]  : d_k[16:0];
      s1_l_mag_in  = d_l[17]  ? n_l[16:0]  : d_l[16:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s1_m_ff       <= s1_m_in;
         s1_h_ff       <= s1_h_in;
         s1_n_ff       <= s1_n_in;
         s1_gna_bar_ff <= s1_gna_bar_in;
         s1_gk_bar_ff  <= s1_gk_bar_in;
         s1_gl_ff      <= s1_gl_in;
         s1_na_neg_ff  <= s1_na_neg_in;
         s1_k_neg_ff   <= s1_k_neg_in;
         s1_l_neg_ff   <= s1_l_neg_in;
         s1_na_mag_ff  <= s1_na_mag_in;
         s1_k_mag_ff   <= s1_k_mag_in;
         s1_l_mag_ff   <= s1_l_mag_in;
      end
   end

   // ---------------- Stage 2: m*m, n*n, leak current magnitude ----------------
   logic [GATE_W-1:0] s2_mm_ff, s2_nn_ff, s2_mm_in, s2_nn_in;
   logic [GATE_W-1:0] s2_m_ff, s2_h_ff, s2_n_ff;
   logic [COND_W-1:0] s2_gna_bar_ff, s2_gk_bar_ff, s2_gl_ff;
   logic              s2_na_neg_ff, s2_k_neg_ff, s2_l_neg_ff;
   logic [16:0]       s2_na_mag_ff, s2_k_mag_ff;
   logic [26:0]       il_prod;
   logic [25:0]       s2_il_mag_ff, s2_il_mag_in;

   always_comb begin
      s2_mm_in     = gate_mul(s1_m_ff, s1_m_ff);
      s2_nn_in     = gate_mul(s1_n_ff, s1_n_ff);
      il_prod      = mul_round(s1_gl_ff, s1_l_mag_ff);
      s2_il_mag_in = il_prod[25:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s2_mm_ff      <= s2_mm_in;
         s2_nn_ff      <= s2_nn_in;
         s2_il_mag_ff  <= s2_il_mag_in;
         s2_m_ff       <= s1_m_ff;
         s2_h_ff       <= s1_h_ff;
         s2_n_ff       <= s1_n_ff;
         s2_gna_bar_ff <= s1_gna_bar_ff;
         s2_gk_bar_ff  <= s1_gk_bar_ff;
         s2_gl_ff      <= s1_gl_ff;
         s2_na_neg_ff  <= s1_na_neg_ff;
         s2_k_neg_ff   <= s1_k_neg_ff;
         s2_l_neg_ff   <= s1_l_neg_ff;
         s2_na_mag_ff  <= s1_na_mag_ff;
         s2_k_mag_ff   <= s1_k_mag_ff;
      end
   end

   // ---------------- Stage 3: m^3, n^3 ----------------
   logic [GATE_W-1:0] s3_m3_ff, s3_n3_ff, s3_m3_in, s3_n3_in;
   logic [GATE_W-1:0] s3_h_ff, s3_n_ff;
   logic [COND_W-1:0] s3_gna_bar_ff, s3_gk_bar_ff, s3_gl_ff;
   logic              s3_na_neg_ff, s3_k_neg_ff, s3_l_neg_ff;
   logic [16:0]       s3_na_mag_ff, s3_k_mag_ff;
   logic [25:0]       s3_il_mag_ff;

   always_comb begin
      s3_m3_in = gate_mul(s2_mm_ff, s2_m_ff);
      s3_n3_in = gate_mul(s2_nn_ff, s2_n_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         s3_m3_ff      <= s3_m3_in;
         s3_n3_ff      <= s3_n3_in;
         s3_h_ff       <= s2_h_ff;
         s3_n_ff       <= s2_n_ff;
         s3_gna_bar_ff <= s2_gna_bar_ff;
         s3_gk_bar_ff  <= s2_gk_bar_ff;
         s3_gl_ff      <= s2_gl_ff;
         s3_na_neg_ff  <= s2_na_neg_ff;
         s3_k_neg_ff   <= s2_k_neg_ff;
         s3_l_neg_ff   <= s2_l_neg_ff;
         s3_na_mag_ff  <= s2_na_mag_ff;
         s3_k_mag_ff   <= s2_k_mag_ff;
         s3_il_mag_ff  <= s2_il_mag_ff;
      end
   end

   // ---------------- Stage 4: m^3*h, n^4 ----------------
   logic [GATE_W-1:0] s4_m3h_ff, s4_n4_ff, s4_m3h_in, s4_n4_in;
   logic [COND_W-1:0] s4_gna_bar_ff, s4_gk_bar_ff, s4_gl_ff;
   logic              s4_na_neg_ff, s4_k_neg_ff, s4_l_neg_ff;
   logic [16:0]       s4_na_mag_ff, s4_k_mag_ff;
   logic [25:0]       s4_il_mag_ff;

   always_comb begin
      s4_m3h_in = gate_mul(s3_m3_ff, s3_h_ff);
      s4_n4_in  = gate_mul(s3_n3_ff, s3_n_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         s4_m3h_ff     <= s4_m3h_in;
         s4_n4_ff      <= s4_n4_in;
         s4_gna_bar_ff <= s3_gna_bar_ff;
         s4_gk_bar_ff  <= s3_gk_bar_ff;
         s4_gl_ff      <= s3_gl_ff;
         s4_na_neg_ff  <= s3_na_neg_ff;
         s4_k_neg_ff   <= s3_k_neg_ff;
         s4_l_neg_ff   <= s3_l_neg_ff;
         s4_na_mag_ff  <= s3_na_mag_ff;
         s4_k_mag_ff   <= s3_k_mag_ff;
         s4_il_mag_ff  <= s3_il_mag_ff;
      end
   end

   // ---------------- Stage 5: gna, gk ----------------
   logic [COND_W-1:0] s5_gna_ff, s5_gk_ff, s5_gna_in, s5_gk_in, s5_gl_ff;
   logic [26:0]       gna_prod, gk_prod;
   logic              s5_na_neg_ff, s5_k_neg_ff, s5_l_neg_ff;
   logic [16:0]       s5_na_mag_ff, s5_k_mag_ff;
   logic [25:0]       s5_il_mag_ff;

   always_comb begin
      gna_prod  = mul_round(s4_gna_bar_ff, s4_m3h_ff);
      gk_prod   = mul_round(s4_gk_bar_ff, s4_n4_ff);
      s5_gna_in = gna_prod[COND_W-1:0];
      s5_gk_in  = gk_prod[COND_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         s5_gna_ff    <= s5_gna_in;
         s5_gk_ff     <= s5_gk_in;
         s5_gl_ff     <= s4_gl_ff;
         s5_na_neg_ff <= s4_na_neg_ff;
         s5_k_neg_ff  <= s4_k_neg_ff;
         s5_l_neg_ff  <= s4_l_neg_ff;
         s5_na_mag_ff <= s4_na_mag_ff;
         s5_k_mag_ff  <= s4_k_mag_ff;
         s5_il_mag_ff <= s4_il_mag_ff;
      end
   end

   // ---------------- Stage 6: ion current magnitudes, total slope, signed leak ----------------
   logic [26:0]        ina_prod, ik_prod;
   logic [25:0]        s6_ina_mag_ff, s6_ik_mag_ff, s6_ina_mag_in, s6_ik_mag_in;
   logic [STOT_W-1:0]  s6_stot_ff, s6_stot_in;
   logic signed [26:0] s6_il_ff, s6_il_in;
   logic [COND_W-1:0]  s6_gna_ff, s6_gk_ff;
   logic               s6_na_neg_ff, s6_k_neg_ff;

   always_comb begin
      ina_prod      = mul_round(s5_gna_ff, s5_na_mag_ff);
      ik_prod       = mul_round(s5_gk_ff, s5_k_mag_ff);
      s6_ina_mag_in = ina_prod[25:0];
      s6_ik_mag_in  = ik_prod[25:0];
      s6_stot_in    = STOT_W'(s5_gna_ff) + STOT_W'(s5_gk_ff) + STOT_W'(s5_gl_ff);
      s6_il_in      = s5_l_neg_ff ? (27'sd0 - $signed({1'b0, s5_il_mag_ff}))
                                  : $signed({1'b0, s5_il_mag_ff});
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         s6_ina_mag_ff <= s6_ina_mag_in;
         s6_ik_mag_ff  <= s6_ik_mag_in;
         s6_stot_ff    <= s6_stot_in;
         s6_il_ff      <= s6_il_in;
         s6_gna_ff     <= s5_gna_ff;
         s6_gk_ff      <= s5_gk_ff;
         s6_na_neg_ff  <= s5_na_neg_ff;
         s6_k_neg_ff   <= s5_k_neg_ff;
      end
   end

   // ---------------- Stage 7: sign, total, saturate (output register) ----------------
   logic signed [26:0]  ina_s, ik_s;
   logic signed [28:0]  itot_s;
   logic [ION_W-1:0]    s7_ina_ff, s7_ik_ff, s7_ina_in, s7_ik_in;
   logic [TOT_W-1:0]    s7_itot_ff, s7_itot_in;
   logic [COND_W-1:0]   s7_gna_ff, s7_gk_ff;
   logic [STOT_W-1:0]   s7_stot_ff;

   always_comb begin
      ina_s  = s6_na_neg_ff ? (27'sd0 - $signed({1'b0, s6_ina_mag_ff}))
                            : $signed({1'b0, s6_ina_mag_ff});
      ik_s   = s6_k_neg_ff  ? (27'sd0 - $signed({1'b0, s6_ik_mag_ff}))
                            : $signed({1'b0, s6_ik_mag_ff});
      itot_s = 29'(s6_il_ff) + 29'(ina_s) + 29'(ik_s);
      if (ina_s > ION_CUR_MAX) begin
         s7_ina_in = ION_CUR_MAX[ION_W-1:0];
      end else if (ina_s < ION_CUR_MIN) begin
         s7_ina_in = ION_CUR_MIN[ION_W-1:0];
      end else begin
         s7_ina_in = ina_s[ION_W-1:0];
      end
      if (ik_s > ION_CUR_MAX) begin
         s7_ik_in = ION_CUR_MAX[ION_W-1:0];
      end else if (ik_s < ION_CUR_MIN) begin
         s7_ik_in = ION_CUR_MIN[ION_W-1:0];
      end else begin
         s7_ik_in = ik_s[ION_W-1:0];
      end
      if (itot_s > TOT_CUR_MAX) begin
         s7_itot_in = TOT_CUR_MAX[TOT_W-1:0];
      end else if (itot_s < TOT_CUR_MIN) begin
         s7_itot_in = TOT_CUR_MIN[TOT_W-1:0];
      end else begin
         s7_itot_in = itot_s[TOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         s7_ina_ff  <= s7_ina_in;
         s7_ik_ff   <= s7_ik_in;
         s7_itot_ff <= s7_itot_in;
         s7_gna_ff  <= s6_gna_ff;
         s7_gk_ff   <= s6_gk_ff;
         s7_stot_ff <= s6_stot_ff;
      end
   end

   // Output word pack
   assign rsp_tvalid = ctrl.valid[NUM_STAGES-1];
   assign rsp_tdata  = {4'd0, s7_stot_ff, s7_gk_ff, s7_gna_ff, s7_itot_ff, s7_ik_ff, s7_ina_ff};

endmodule

`default_nettype wire

/* design/hhmc_pipe_ctrl.sv */
// Valid and load-enable chain for the current pipeline.
// Each stage loads when it is empty or its successor moves; uses hhmc_pkg.
`default_nettype none

module hhmc_pipe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic                  out_ready,
   output hhmc_pkg::pipe_ctrl_type    ctrl
);
   import hhmc_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // Backward ready chain: a stage loads if empty or if the next one moves
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // Valid bits follow the data
   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready   = load[0];
   assign ctrl.load  = load;
   assign ctrl.valid = valid_ff;

endmodule

`default_nettype wire
